[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/rvse_pkg.sv]
package rvse_pkg;

  // instruction class on the mode field
  localparam logic [2:0] MODE_LOAD    = 3'd0;
  localparam logic [2:0] MODE_STORE   = 3'd1;
  localparam logic [2:0] MODE_ALU_IMM = 3'd2;
  localparam logic [2:0] MODE_ALU_REG = 3'd3;
  localparam logic [2:0] MODE_LUI     = 3'd4;
  localparam logic [2:0] MODE_JAL     = 3'd5;
  localparam logic [2:0] MODE_BRANCH  = 3'd6;

  // loads
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // stores
  localparam logic [2:0] F3_SB = 3'd0;
  localparam logic [2:0] F3_SH = 3'd1;
  localparam logic [2:0] F3_SW = 3'd2;

  // alu
  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SUB = 3'd2;
  localparam logic [6:0] F7_ADD = 7'b0000000;
  localparam logic [6:0] F7_MUL = 7'b0000001;

  // branches
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [31:0] PC_STEP  = 32'd4;
  localparam logic [31:0] PC_RESET = 32'h0000_0000;
  localparam logic [4:0]  RA_INDEX = 5'd1;
  localparam logic [4:0]  X0_INDEX = 5'd0;

  // data memory request, four byte lanes
  typedef struct packed {
    logic            rd_en;
    logic [3:0]      wr_mask;
    logic [31:0]     addr;
    logic [3:0][7:0] wdata;
  } dmem_req_t;

  typedef struct packed {
    logic busy;
  } dmem_stat_t;

endpackage

[src/rvse_if.sv]
interface rvse_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] instruction_word;

  modport source (output valid, output mode, output instruction_word, input ready);
  modport sink (input valid, input mode, input instruction_word, output ready);
endinterface

interface rvse_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_address;
  logic        reg_written;
  logic [4:0]  dest_index;
  logic [31:0] write_value;
  logic        misaligned;

  modport source (output valid, output next_address, output reg_written,
                  output dest_index, output write_value, output misaligned,
                  input ready);
  modport sink (input valid, input next_address, input reg_written,
                input dest_index, input write_value, input misaligned,
                output ready);
endinterface

[src/rv32_subset_execute_top.sv]
// channel   | dir | handshake      | payload
// in_chan   | in  | valid / ready  | mode, instruction_word
// out_chan  | out | valid / ready  | next_address, reg_written, dest_index,
//           |     |                | write_value, misaligned
// cfg       | in  | cfg_wr_en      | cfg_wr_data (start address, loads the pc)
//
// one instruction per cycle unless out_chan.ready is low or the memory clears;
// beats pass the operand read register, then the result register with load data
// reset: the data memory is zeroed one row of four bytes a cycle, all MEM_BYTES/4
// rows (1024 at the default), with in_chan.ready low; cfg writes still taken
// MEM_BYTES must be a power of two, not checked; byte addrs wrap mod MEM_BYTES
// out_chan.ready low holds the result register; one more beat waits in the
// operand stage, then in_chan.ready drops
`include "assert_macros.svh"

module rv32_subset_execute_top #(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  rvse_in_if.sink     in_chan,
  rvse_out_if.source  out_chan
);

  // handshake
  logic in_acc;
  logic out_acc;
  logic s2_free;
  logic s1_adv;

  // program counter
  logic [31:0] pc_r;

  // register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic        rf_we;

  // operand stage
  logic        s1_valid_r;
  logic [2:0]  s1_mode_r;
  logic [31:0] s1_word_r;
  logic [31:0] rf_a_raw_r;
  logic [31:0] rf_b_raw_r;
  logic        a_vld_r;
  logic        b_vld_r;
  logic        a_byp_r;
  logic        b_byp_r;
  logic [31:0] byp_val_r;
  logic [31:0] op_a;
  logic [31:0] op_b;

  // execute results
  logic [31:0] ex_next;
  logic        ex_wr;
  logic [4:0]  ex_dst;
  logic [31:0] ex_val;
  logic        ex_mis;
  logic        ex_load;
  logic [31:0] mem_addr;
  logic        st_en;

  // result stage
  logic        s2_valid_r;
  logic [31:0] s2_next_r;
  logic        s2_wr_r;
  logic [4:0]  s2_dst_r;
  logic [31:0] s2_val_r;
  logic        s2_mis_r;
  logic        s2_load_r;
  logic [2:0]  s2_f3_r;
  logic [1:0]  s2_off_r;
  logic [31:0] ld_val;
  logic [31:0] wval;

  rvse_pkg::dmem_req_t  dmem_req;
  rvse_pkg::dmem_stat_t dmem_stat;
  logic [3:0][7:0]      dmem_rdata;

  assign s2_free       = !s2_valid_r || out_chan.ready;
  assign s1_adv        = s1_valid_r && s2_free;
  assign in_chan.ready = !dmem_stat.busy && (!s1_valid_r || s1_adv);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign out_acc       = s2_valid_r && out_chan.ready;
  assign rf_we         = out_acc && s2_wr_r;

  // register file: write on result beat, registered read on accept
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[s2_dst_r] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rf_a_raw_r <= rf_mem[in_chan.instruction_word[19:15]];
      rf_b_raw_r <= rf_mem[in_chan.instruction_word[24:20]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (rf_we) begin
      rf_vld_r[s2_dst_r] <= 1'b1;
    end
  end

  // operand stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= in_chan.mode;
      s1_word_r <= in_chan.instruction_word;
      a_vld_r   <= rf_vld_r[in_chan.instruction_word[19:15]];
      b_vld_r   <= rf_vld_r[in_chan.instruction_word[24:20]];
      // write landing on the same edge as the read
      a_byp_r   <= rf_we && (s2_dst_r == in_chan.instruction_word[19:15]);
      b_byp_r   <= rf_we && (s2_dst_r == in_chan.instruction_word[24:20]);
      byp_val_r <= wval;
    end
  end

  // result stage holds the one write still pending, newest first
  always_comb begin
    if (s2_valid_r && s2_wr_r && (s2_dst_r == s1_word_r[19:15])) begin
      op_a = wval;
    end else if (a_byp_r) begin
      op_a = byp_val_r;
    end else if (a_vld_r) begin
      op_a = rf_a_raw_r;
    end else begin
      op_a = '0;
    end
    if (s2_valid_r && s2_wr_r && (s2_dst_r == s1_word_r[24:20])) begin
      op_b = wval;
    end else if (b_byp_r) begin
      op_b = byp_val_r;
    end else if (b_vld_r) begin
      op_b = rf_b_raw_r;
    end else begin
      op_b = '0;
    end
  end

  // execute
  always_comb begin
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] pc4;
    logic        take;

    rd   = s1_word_r[11:7];
    f3   = s1_word_r[14:12];
    f7   = s1_word_r[31:25];
    immi = {{20{s1_word_r[31]}}, s1_word_r[31:20]};
    imms = {{20{s1_word_r[31]}}, s1_word_r[31:25], s1_word_r[11:7]};
    immb = {{19{s1_word_r[31]}}, s1_word_r[31], s1_word_r[7], s1_word_r[30:25],
            s1_word_r[11:8], 1'b0};
    immj = {{11{s1_word_r[31]}}, s1_word_r[31], s1_word_r[19:12], s1_word_r[20],
            s1_word_r[30:21], 1'b0};
    pc4  = pc_r + rvse_pkg::PC_STEP;
    take = 1'b0;

    mem_addr = op_a + ((s1_mode_r == rvse_pkg::MODE_STORE) ? imms : immi);
    st_en    = 1'b0;
    ex_next  = pc4;
    ex_wr    = 1'b0;
    ex_dst   = rd;
    ex_val   = '0;
    ex_mis   = 1'b0;

    unique case (s1_mode_r)
      rvse_pkg::MODE_LOAD: begin
        ex_wr = 1'b1;
        unique case (f3)
          rvse_pkg::F3_LB, rvse_pkg::F3_LBU: ex_wr = 1'b1;
          rvse_pkg::F3_LH, rvse_pkg::F3_LHU: begin
            if (mem_addr[0]) begin
              ex_mis = 1'b1;
              ex_wr  = 1'b0;
            end
          end
          rvse_pkg::F3_LW: begin
            if (mem_addr[1:0] != 2'b00) begin
              ex_mis = 1'b1;
              ex_wr  = 1'b0;
            end
          end
          default: ex_wr = 1'b0;
        endcase
      end
      rvse_pkg::MODE_STORE: begin
        st_en = (f3 == rvse_pkg::F3_SB) || (f3 == rvse_pkg::F3_SH) ||
                (f3 == rvse_pkg::F3_SW);
      end
      rvse_pkg::MODE_ALU_IMM: begin
        ex_wr = 1'b1;
        unique case (f3)
          rvse_pkg::F3_ADD: ex_val = op_a + immi;
          rvse_pkg::F3_SLL: ex_val = op_a << immi[4:0];
          rvse_pkg::F3_SUB: ex_val = op_a - immi;
          default:          ex_val = op_a;
        endcase
      end
      rvse_pkg::MODE_ALU_REG: begin
        ex_wr = 1'b1;
        unique case (f3)
          rvse_pkg::F3_ADD: begin
            if (f7 == rvse_pkg::F7_ADD) begin
              ex_val = op_a + op_b;
            end else if (f7 == rvse_pkg::F7_MUL) begin
              ex_val = op_a * op_b;
            end else begin
              ex_val = '0;
            end
          end
          rvse_pkg::F3_SUB: ex_val = op_a - op_b;
          default:          ex_val = '0;
        endcase
      end
      rvse_pkg::MODE_LUI: begin
        ex_wr  = 1'b1;
        ex_val = {s1_word_r[31:12], 12'h000};
      end
      rvse_pkg::MODE_JAL: begin
        ex_wr   = 1'b1;
        ex_dst  = rvse_pkg::RA_INDEX;
        ex_val  = pc4;
        ex_next = pc_r + immj;
      end
      rvse_pkg::MODE_BRANCH: begin
        unique case (f3)
          rvse_pkg::F3_BEQ:  take = (op_a == op_b);
          rvse_pkg::F3_BNE:  take = (op_a != op_b);
          rvse_pkg::F3_BLT:  take = ($signed(op_a) < $signed(op_b));
          rvse_pkg::F3_BGE:  take = ($signed(op_a) >= $signed(op_b));
          rvse_pkg::F3_BLTU: take = (op_a < op_b);
          rvse_pkg::F3_BGEU: take = (op_a >= op_b);
          default:           take = 1'b0;
        endcase
        if (take) begin
          ex_next = pc_r + immb;
        end
      end
      default: ex_wr = 1'b0;
    endcase

    // x0 and skipped writes report nothing
    if (!ex_wr || (ex_dst == rvse_pkg::X0_INDEX)) begin
      ex_wr  = 1'b0;
      ex_dst = rvse_pkg::X0_INDEX;
      ex_val = '0;
    end
    ex_load = ex_wr && (s1_mode_r == rvse_pkg::MODE_LOAD);
  end

  // memory request, store bytes rotated onto their lanes
  always_comb begin
    logic [1:0] k;
    dmem_req.rd_en = s1_adv && (s1_mode_r == rvse_pkg::MODE_LOAD);
    dmem_req.addr  = mem_addr;
    for (int j = 0; j < 4; j++) begin
      k = 2'(j) - mem_addr[1:0];
      dmem_req.wdata[j] = op_b[8*k +: 8];
      if (s1_word_r[14:12] == rvse_pkg::F3_SW) begin
        dmem_req.wr_mask[j] = s1_adv && st_en;
      end else if (s1_word_r[14:12] == rvse_pkg::F3_SH) begin
        dmem_req.wr_mask[j] = s1_adv && st_en && (k < 2'd2);
      end else begin
        dmem_req.wr_mask[j] = s1_adv && st_en && (k == 2'd0);
      end
    end
  end

  rvse_dmem #(
    .MEM_BYTES(MEM_BYTES)
  ) u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dmem_req),
    .rdata (dmem_rdata),
    .stat  (dmem_stat)
  );

  // program counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rvse_pkg::PC_RESET;
    end else if (cfg_wr_en) begin
      pc_r <= cfg_wr_data;
    end else if (s1_adv) begin
      pc_r <= ex_next;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (out_acc) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_next_r <= ex_next;
      s2_wr_r   <= ex_wr;
      s2_dst_r  <= ex_dst;
      s2_val_r  <= ex_val;
      s2_mis_r  <= ex_mis;
      s2_load_r <= ex_load;
      s2_f3_r   <= s1_word_r[14:12];
      s2_off_r  <= mem_addr[1:0];
    end
  end

  // load formatting from the lane bytes
  always_comb begin
    logic [3:0][7:0] lb;
    for (int i = 0; i < 4; i++) begin
      lb[i] = dmem_rdata[s2_off_r + 2'(i)];
    end
    unique case (s2_f3_r)
      rvse_pkg::F3_LB:  ld_val = {{24{lb[0][7]}}, lb[0]};
      rvse_pkg::F3_LH:  ld_val = {{16{lb[1][7]}}, lb[1], lb[0]};
      rvse_pkg::F3_LW:  ld_val = lb;
      rvse_pkg::F3_LBU: ld_val = {24'h000000, lb[0]};
      rvse_pkg::F3_LHU: ld_val = {16'h0000, lb[1], lb[0]};
      default:          ld_val = '0;
    endcase
  end

  assign wval = s2_load_r ? ld_val : s2_val_r;

  assign out_chan.valid        = s2_valid_r;
  assign out_chan.next_address = s2_next_r;
  assign out_chan.reg_written  = s2_wr_r;
  assign out_chan.dest_index   = s2_dst_r;
  assign out_chan.write_value  = wval;
  assign out_chan.misaligned   = s2_mis_r;

  `ASSERT_SAME(a_mis_no_write, s2_valid_r && s2_mis_r, !s2_wr_r && !s2_load_r)
  `ASSERT_SAME(a_write_not_x0, s2_valid_r && s2_wr_r, s2_dst_r != rvse_pkg::X0_INDEX)
  `ASSERT_SAME(a_idle_zero, s2_valid_r && !s2_wr_r, (s2_dst_r == rvse_pkg::X0_INDEX) && (wval == 32'h0))
  `ASSERT_NEXT(a_s1_hold, s1_valid_r && !s2_free, s1_valid_r && $stable(s1_word_r))

endmodule

[src/rvse_dmem.sv]
module rvse_dmem #(
  parameter int MEM_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rvse_pkg::dmem_req_t  req,
  output logic [3:0][7:0]      rdata,
  output rvse_pkg::dmem_stat_t stat
);

  localparam int AW    = $clog2(MEM_BYTES);
  localparam int RW    = AW - 2;
  localparam int DEPTH = MEM_BYTES / 4;

  logic [RW-1:0] clr_row_r;
  logic [RW-1:0] clr_row_nxt;
  logic          clr_busy_r;
  logic          clr_busy_nxt;

  // zero sweep over all rows after reset
  always_comb begin
    clr_row_nxt  = clr_row_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_row_nxt = clr_row_r + RW'(1);
      if (clr_row_r == RW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_row_r  <= clr_row_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  assign stat.busy = clr_busy_r;

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_r;
    logic [RW-1:0] row;
    logic [RW-1:0] wr_row;
    logic [7:0]    wr_byte;
    logic          wr_en;

    // lanes below the start offset belong to the next row
    assign row     = req.addr[AW-1:2] + RW'(req.addr[1:0] > 2'(j));
    assign wr_en   = clr_busy_r | req.wr_mask[j];
    assign wr_row  = clr_busy_r ? clr_row_r : row;
    assign wr_byte = clr_busy_r ? 8'h00 : req.wdata[j];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_row] <= wr_byte;
      end
    end

    always_ff @(posedge clk) begin
      if (req.rd_en) begin
        rd_r <= mem[row];
      end
    end

    assign rdata[j] = rd_r;
  end

endmodule
